### sv/modbus_serial_rx_framer_assert.svh
// Assertion macros shared by the Modbus receive framer modules.
// Depends on nothing; included by files that carry assertions.
`ifndef MODBUS_SERIAL_RX_FRAMER_ASSERT_SVH
`define MODBUS_SERIAL_RX_FRAMER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define MRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define MRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mrx_pkg.sv
// Package for the Modbus receive framer: command, status and timer codes, widths, CRC step, hex decode.
// Depends on nothing.
package mrx_pkg;
  localparam int BufferBytes = 256;
  localparam int AddrW = $clog2(BufferBytes);
  localparam int PosW = AddrW + 1;

  localparam logic [2:0] CMD_BYTE = 3'd0;
  localparam logic [2:0] CMD_TIMER = 3'd1;
  localparam logic [2:0] CMD_TAKE = 3'd2;
  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_ENABLE = 3'd4;
  localparam logic [2:0] CMD_DISABLE = 3'd5;
  localparam logic [2:0] CMD_CLAIM = 3'd6;
  localparam logic [2:0] CMD_RELEASE = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NODATA = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  localparam logic [1:0] TMR_LEAVE = 2'd0;
  localparam logic [1:0] TMR_RESTART = 2'd1;
  localparam logic [1:0] TMR_STOP = 2'd2;

  // One queued word from the front to the back.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic       rx_fault;
    logic [7:0] read_index;
  } mrx_word_t;

  // Byte-wide Modbus CRC-16 step (reflected polynomial 0xA001).
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  // Hex character (digits, upper-case A-F) to nibble value; 0xFF for any other character.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v;
  endfunction
endpackage

### sv/mrx_front.sv
// Front part: accepts input words into a two-entry queue.
// Depends on mrx_pkg and modbus_serial_rx_framer_assert.svh.
module mrx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrx_pkg::mrx_word_t in_word,
  output logic              q_valid,
  output mrx_pkg::mrx_word_t q_word,
  input  logic              q_pop
);
  import mrx_pkg::*;
  `include "modbus_serial_rx_framer_assert.svh"

  mrx_word_t ent_r [2];
  logic      rd_r, wr_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_word = ent_r[rd_r];

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= in_word;
  end

  `MRX_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, cnt_r != 2'd0)
  `MRX_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `MRX_ASSERT_NEXT(a_full_stall, clk, rst_n, push && !q_pop && cnt_r == 2'd1, in_stall)
endmodule

### sv/mrx_back.sv
// Back part: receiver state machine, frame buffer, checks and output register.
// Depends on mrx_pkg and modbus_serial_rx_framer_assert.svh.
module mrx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ascii_mode,
  input  logic               q_valid,
  input  mrx_pkg::mrx_word_t q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [1:0]         out_timer_action,
  output logic [7:0]         out_slave_address,
  output logic [7:0]         out_pdu_length,
  output logic [7:0]         out_data_byte,
  output logic               out_granted
);
  import mrx_pkg::*;
  `include "modbus_serial_rx_framer_assert.svh"

  typedef enum logic [2:0] {
    RX_INIT, RX_IDLE, RX_RCV, RX_WAIT_EOF, RX_ERROR, RX_COMPLETE, RX_OFF
  } rx_state_t;

  rx_state_t      state_r, state_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic           low_r, low_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic [7:0]     lrc_r, lrc_nxt;
  logic [7:0]     addr0_r, addr0_nxt;
  logic [7:0]     cur_r;
  logic [7:0]     mem [BufferBytes];
  logic           we;
  logic [AddrW-1:0] wa;
  logic [7:0]     wd;

  logic           vld_r;
  logic [1:0]     status_r, status_nxt, timer_r, timer_nxt;
  logic [7:0]     addr_r, addr_nxt, plen_r, plen_nxt;
  logic           grant_r, grant_nxt, rd_ok_r, rd_ok_nxt;
  logic [7:0]     data_r;

  logic [PosW-1:0] ridx;
  logic [PosW-1:0] n;
  logic [7:0]     b, v, hv;
  logic           ok;
  rx_state_t      s;

  // Pop when the output register is free or being drained.
  assign q_pop = q_valid && (!vld_r || !out_stall);
  assign ridx = {1'b0, q_word.read_index} + PosW'(1);
  assign b = q_word.rx_byte;
  assign hv = hex_value(b);

  // Next-state logic for one word.
  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    low_nxt = low_r;
    crc_nxt = crc_r;
    lrc_nxt = lrc_r;
    addr0_nxt = addr0_r;
    we = 1'b0;
    wa = pos_r[AddrW-1:0];
    wd = b;
    status_nxt = ST_OK;
    timer_nxt = TMR_LEAVE;
    addr_nxt = 8'd0;
    plen_nxt = 8'd0;
    grant_nxt = 1'b0;
    rd_ok_nxt = 1'b0;
    v = cur_r | hv;
    ok = 1'b0;
    n = '0;
    s = state_r;
    case (q_word.command)
      CMD_BYTE: begin
        if (q_word.rx_fault && s != RX_COMPLETE && s != RX_OFF) s = RX_ERROR;
        if (ascii_mode && (s == RX_INIT || s == RX_ERROR)) s = RX_IDLE;
        state_nxt = s;
        case (s)
          RX_INIT, RX_ERROR: timer_nxt = TMR_RESTART;
          RX_IDLE: begin
            if (!ascii_mode) begin
              we = 1'b1;
              wa = '0;
              addr0_nxt = b;
              crc_nxt = crc_step(16'hFFFF, b);
              lrc_nxt = b;
              pos_nxt = PosW'(1);
              low_nxt = 1'b0;
              state_nxt = RX_RCV;
              timer_nxt = TMR_RESTART;
            end else if (b == 8'h3A) begin
              pos_nxt = '0;
              low_nxt = 1'b0;
              crc_nxt = 16'hFFFF;
              lrc_nxt = 8'd0;
              state_nxt = RX_RCV;
              timer_nxt = TMR_RESTART;
            end
          end
          RX_RCV: begin
            timer_nxt = TMR_RESTART;
            if (pos_r[PosW-1]) begin
              state_nxt = RX_ERROR;
            end else if (!ascii_mode) begin
              we = 1'b1;
              if (pos_r == '0) addr0_nxt = b;
              crc_nxt = crc_step(crc_r, b);
              lrc_nxt = lrc_r + b;
              pos_nxt = pos_r + PosW'(1);
            end else if (b == 8'h3A) begin
              pos_nxt = '0;
              low_nxt = 1'b0;
              crc_nxt = 16'hFFFF;
              lrc_nxt = 8'd0;
            end else if (b == 8'h0D) begin
              state_nxt = RX_WAIT_EOF;
            end else if (low_r) begin
              we = 1'b1;
              wd = v;
              if (pos_r == '0) addr0_nxt = v;
              crc_nxt = crc_step(crc_r, v);
              lrc_nxt = lrc_r + v;
              pos_nxt = pos_r + PosW'(1);
              low_nxt = 1'b0;
            end else begin
              // The high nibble lands in the buffer right away.
              we = 1'b1;
              wd = {hv[3:0], 4'h0};
              low_nxt = 1'b1;
            end
          end
          RX_WAIT_EOF: begin
            if (b == 8'h0A) begin
              timer_nxt = TMR_STOP;
              state_nxt = RX_COMPLETE;
            end else if (b == 8'h3A) begin
              pos_nxt = '0;
              low_nxt = 1'b0;
              crc_nxt = 16'hFFFF;
              lrc_nxt = 8'd0;
              state_nxt = RX_RCV;
            end else begin
              state_nxt = RX_IDLE;
            end
          end
          default: state_nxt = RX_ERROR;
        endcase
      end
      CMD_TIMER: begin
        timer_nxt = TMR_STOP;
        if (!ascii_mode && state_r == RX_RCV) state_nxt = RX_COMPLETE;
        else if (state_r != RX_COMPLETE && state_r != RX_OFF) state_nxt = RX_IDLE;
      end
      CMD_TAKE: begin
        if (state_r != RX_COMPLETE) begin
          status_nxt = ST_NODATA;
        end else begin
          state_nxt = RX_IDLE;
          if (pos_r[PosW-1]) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            ok = ascii_mode ? (pos_r >= PosW'(3) && lrc_r == 8'd0)
                            : (pos_r >= PosW'(4) && crc_r == 16'd0);
            n = pos_r - (ascii_mode ? PosW'(2) : PosW'(3));
            if (ok) begin
              addr_nxt = addr0_r;
              plen_nxt = (n > PosW'(255)) ? 8'hFF : n[7:0];
            end else begin
              status_nxt = ST_BAD;
            end
          end
        end
      end
      CMD_READ: rd_ok_nxt = (ridx < PosW'(BufferBytes));
      CMD_ENABLE: begin
        state_nxt = RX_INIT;
        timer_nxt = TMR_RESTART;
      end
      CMD_DISABLE: timer_nxt = TMR_STOP;
      CMD_CLAIM: begin
        if (state_r == RX_IDLE || state_r == RX_COMPLETE || state_r == RX_OFF) begin
          state_nxt = RX_OFF;
          grant_nxt = 1'b1;
        end
      end
      default: begin
        if (state_r == RX_COMPLETE || state_r == RX_OFF) state_nxt = RX_IDLE;
      end
    endcase
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RX_IDLE;
      pos_r <= '0;
      low_r <= 1'b0;
      crc_r <= 16'hFFFF;
      lrc_r <= 8'd0;
      vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        state_r <= state_nxt;
        pos_r <= pos_nxt;
        low_r <= low_nxt;
        crc_r <= crc_nxt;
        lrc_r <= lrc_nxt;
        vld_r <= 1'b1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr0_r <= addr0_nxt;
      status_r <= status_nxt;
      timer_r <= timer_nxt;
      addr_r <= addr_nxt;
      plen_r <= plen_nxt;
      grant_r <= grant_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  // Frame buffer: one write and two registered reads per popped word. The second read
  // keeps cur_r equal to the buffer byte at the write position.
  always_ff @(posedge clk) begin
    if (q_pop && we) mem[wa] <= wd;
    if (q_pop) begin
      data_r <= mem[ridx[AddrW-1:0]];
      cur_r <= (we && wa == pos_nxt[AddrW-1:0]) ? wd : mem[pos_nxt[AddrW-1:0]];
    end
  end

  assign out_valid = vld_r;
  assign out_status = status_r;
  assign out_timer_action = timer_r;
  assign out_slave_address = addr_r;
  assign out_pdu_length = plen_r;
  assign out_data_byte = rd_ok_r ? data_r : 8'd0;
  assign out_granted = grant_r;

  `MRX_ASSERT_IMP(a_pop_free, clk, rst_n, q_pop, !vld_r || !out_stall)
  `MRX_ASSERT_NEXT(a_hold, clk, rst_n, vld_r && out_stall, vld_r && $stable(status_r))
  `MRX_ASSERT_IMP(a_pos_max, clk, rst_n, 1'b1, pos_r <= PosW'(BufferBytes))
endmodule

### sv/modbus_serial_rx_framer.sv
// Modbus serial receive framer (RTU with CRC-16, ASCII with LRC). Each input word is a
// command; each produces exactly one result word. Words enter a two-word queue and the
// back end retires one word per clock while out_stall is low, so the sustained rate is
// one word per cycle; an input word passes through the queue entry and the registered
// result word. Write ascii_mode only while the block is idle.
module modbus_serial_rx_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_ascii_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_rx_byte,
  input  logic       in_rx_fault,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [1:0] out_timer_action,
  output logic [7:0] out_slave_address,
  output logic [7:0] out_pdu_length,
  output logic [7:0] out_data_byte,
  output logic       out_granted
);
  import mrx_pkg::*;

  logic      mode_r;
  mrx_word_t in_word, q_word;
  logic      q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_valid) mode_r <= cfg_ascii_mode;
  end

  assign in_word = '{command: in_command, rx_byte: in_rx_byte,
                     rx_fault: in_rx_fault, read_index: in_read_index};

  mrx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
  );

  mrx_back u_back (
    .clk(clk), .rst_n(rst_n), .ascii_mode(mode_r), .q_valid(q_valid),
    .q_word(q_word), .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_timer_action(out_timer_action),
    .out_slave_address(out_slave_address), .out_pdu_length(out_pdu_length),
    .out_data_byte(out_data_byte), .out_granted(out_granted)
  );
endmodule
